// ===== design/dqkd_pkg.sv =====
// package for the keyed-delete deque: operation, status and sequencer codes
// and the fixed field widths
// no dependencies
package dqkd_pkg;

   localparam int KEY_W            = 32;
   localparam int OP_W             = 3;
   localparam int STATUS_W         = 2;
   localparam int COUNT_W          = 6;
   localparam int DEFAULT_CAPACITY = 32;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_DEL_KEY   = 3'd1,
      OP_DEL_FIRST = 3'd2,
      OP_DEL_LAST  = 3'd3,
      OP_DUMP      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_DUMP
   } state_type;

endpackage

// ===== design/deque_with_keyed_delete.sv =====
// top level of the keyed-delete deque: circular entry store with a small
// sequencer that walks it one entry per cycle for search, shift and dump
// depends on dqkd_pkg and dqkd_ram
//
//   channel   ports                                   handshake
//   command   req_operation, req_key                  start && !busy
//   result    rsp_status, rsp_value, rsp_last,        rsp_valid, one cycle
//             rsp_count
//
// insert, delete-first, delete-last and a delete or dump on an empty list
// finish in idle, result on the following cycle, busy stays low.
// delete by key searches from the front to the match, then shifts each later
// entry one place toward the front to close the gap; a miss searches all entries.
// dump reads from the front, one result per cycle, rsp_last on the back entry.
// the single read port of the entry store sets the pace of every walk.
// reset is synchronous and empties the list; results cannot be stalled.
module deque_with_keyed_delete #(
   parameter int CAPACITY = dqkd_pkg::DEFAULT_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dqkd_pkg::OP_W-1:0]      req_operation,
   input  logic [dqkd_pkg::KEY_W-1:0]     req_key,
   output logic                           rsp_valid,
   output logic [dqkd_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dqkd_pkg::KEY_W-1:0]     rsp_value,
   output logic                           rsp_last,
   output logic [dqkd_pkg::COUNT_W-1:0]   rsp_count
);

   import dqkd_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [KEY_W-1:0]     key_ff, key_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_wr_addr;
   logic [KEY_W-1:0]     mem_wr_data;
   logic [AW-1:0]        mem_rd_addr;
   logic [KEY_W-1:0]     mem_rd_data;

   logic                 accept;
   logic                 is_empty;
   logic                 at_back;
   logic [AW-1:0]        cur_next;
   logic [AW-1:0]        head_dec;
   logic [AW-1:0]        head_inc;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      return (a == LAST_ADDR) ? '0 : AW'(a + 1'b1);
   endfunction

   dqkd_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign is_empty = (count_ff == '0);
   // entry under the read data is the back of the list
   assign at_back  = (CW'(idx_ff + 1'b1) == count_ff);
   assign cur_next = wrap_inc(cur_ff);
   assign head_inc = wrap_inc(head_ff);
   assign head_dec = (head_ff == '0) ? LAST_ADDR : AW'(head_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      wr_ptr_ff     <= wr_ptr_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      wr_ptr_in     = wr_ptr_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      rsp_count_in  = COUNT_W'(count_ff);
      mem_we        = 1'b0;
      mem_wr_addr   = wr_ptr_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_addr   = cur_next;

      unique case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = head_ff;
            cur_in      = head_ff;
            idx_in      = '0;
            key_in      = req_key;
            if (accept) begin
               case (req_operation) inside
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        mem_wr_addr  = head_dec;
                        mem_wr_data  = req_key;
                        head_in      = head_dec;
                        count_in     = CW'(count_ff + 1'b1);
                        rsp_count_in = COUNT_W'(count_in);
                     end
                  end
                  OP_DEL_FIRST, OP_DEL_LAST: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        if (req_operation == OP_DEL_FIRST) begin
                           head_in = head_inc;
                        end
                        count_in     = CW'(count_ff - 1'b1);
                        rsp_count_in = COUNT_W'(count_in);
                     end
                  end
                  OP_DEL_KEY: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                     // unused codes give no transaction
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            cur_in = cur_next;
            idx_in = CW'(idx_ff + 1'b1);
            if (mem_rd_data == key_ff) begin
               if (at_back) begin
                  count_in      = CW'(count_ff - 1'b1);
                  rsp_valid_in  = 1'b1;
                  rsp_count_in  = COUNT_W'(count_in);
                  state_in      = ST_IDLE;
               end else begin
                  // close the gap: next read lands at the entry behind the match
                  wr_ptr_in = cur_ff;
                  state_in  = ST_SHIFT;
               end
            end else if (at_back) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_MISSING;
               state_in      = ST_IDLE;
            end
         end

         ST_SHIFT: begin
            mem_we    = 1'b1;
            wr_ptr_in = cur_ff;
            cur_in    = cur_next;
            idx_in    = CW'(idx_ff + 1'b1);
            if (at_back) begin
               count_in     = CW'(count_ff - 1'b1);
               rsp_valid_in = 1'b1;
               rsp_count_in = COUNT_W'(count_in);
               state_in     = ST_IDLE;
            end
         end

         ST_DUMP: begin
            cur_in       = cur_next;
            idx_in       = CW'(idx_ff + 1'b1);
            rsp_valid_in = 1'b1;
            rsp_value_in = mem_rd_data;
            rsp_last_in  = at_back;
            if (at_back) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_count  = rsp_count_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_partial_only_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> $past(state_ff == ST_DUMP))
      else $error("non-final result outside a dump");

   a_partial_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_status_ff == STAT_OK)
      else $error("non-final result with bad status");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(req_operation == OP_DEL_KEY || req_operation == OP_DUMP))
      else $error("busy raised by a single-cycle command");

   a_shift_not_front: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> idx_ff != '0 && !is_empty)
      else $error("shift started at the front or on an empty list");

endmodule

// ===== design/dqkd_ram.sv =====
// entry store for the keyed-delete deque: one write port, one read port,
// registered read data
// depends on dqkd_pkg for default sizes
module dqkd_ram #(
   parameter int DEPTH = dqkd_pkg::DEFAULT_CAPACITY,
   parameter int WIDTH = dqkd_pkg::KEY_W,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/deque_with_keyed_delete_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for deque_with_keyed_delete: directed and random commands with
// a list predictor in a small scoreboard class; depends on dqkd_pkg and the block's rtl
module deque_with_keyed_delete_tb;
   import dqkd_pkg::*;

   localparam int CAP            = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS   = 140;
   localparam int SEGMENT        = 45;
   localparam int DRAIN_CYCLES   = 2 * CAP + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [OP_W-1:0] OP_FIRST_RESERVED = 3'd5;
   localparam logic [OP_W-1:0] OP_LAST_RESERVED  = 3'd7;

   typedef struct {
      status_type           status;
      logic [KEY_W-1:0]     value;
      logic                 last;
      logic [COUNT_W-1:0]   count;
   } deque_result_type;

   class deque_scoreboard;
      logic [KEY_W-1:0] held [CAP];
      int unsigned      held_n;
      deque_result_type awaited [$];
      int unsigned      errors;

      function void push_result(status_type s, logic [KEY_W-1:0] v, logic l);
         deque_result_type r;
         r.status = s;
         r.value  = v;
         r.last   = l;
         r.count  = held_n[COUNT_W-1:0];
         awaited.push_back(r);
      endfunction

      function void remove_entry(int unsigned pos);
         for (int unsigned j = pos; j + 1 < held_n; j++) held[j] = held[j + 1];
         held_n--;
      endfunction

      // work out the results an accepted command produces and update the list
      function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
         int unsigned idx;
         case (op) inside
            OP_INSERT: begin
               if (held_n >= CAP) begin
                  push_result(STAT_FULL, '0, 1'b1);
               end else begin
                  for (int unsigned j = held_n; j > 0; j--) held[j] = held[j - 1];
                  held[0] = key;
                  held_n++;
                  push_result(STAT_OK, '0, 1'b1);
               end
            end
            OP_DEL_KEY: begin
               if (held_n == 0) begin
                  push_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  idx = 0;
                  while (idx < held_n && held[idx] != key) idx++;
                  if (idx == held_n) begin
                     push_result(STAT_MISSING, '0, 1'b1);
                  end else begin
                     remove_entry(idx);
                     push_result(STAT_OK, '0, 1'b1);
                  end
               end
            end
            OP_DEL_FIRST, OP_DEL_LAST: begin
               if (held_n == 0) begin
                  push_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  remove_entry(op == OP_DEL_FIRST ? 0 : held_n - 1);
                  push_result(STAT_OK, '0, 1'b1);
               end
            end
            OP_DUMP: begin
               if (held_n == 0) begin
                  push_result(STAT_EMPTY, '0, 1'b1);
               end else begin
                  for (int unsigned j = 0; j < held_n; j++)
                     push_result(STAT_OK, held[j], j + 1 == held_n);
               end
            end
            default: ;  // reserved codes give nothing
         endcase
      endfunction

      function void check_result(logic [STATUS_W-1:0] s, logic [KEY_W-1:0] v, logic l,
                                 logic [COUNT_W-1:0] c);
         deque_result_type e;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result status=%0d value=%h last=%b count=%0d",
                        $realtime, s, v, l, c);
            return;
         end
         e = awaited.pop_front();
         if (e.status !== s || e.value !== v || e.last !== l || e.count !== c) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: result mismatch: expected status=%0d value=%h last=%b ",
                         "count=%0d, got status=%0d value=%h last=%b count=%0d"},
                        $realtime, e.status, e.value, e.last, e.count, s, v, l, c);
         end
      endfunction

      function logic [KEY_W-1:0] random_held_key();
         if (held_n == 0) return $urandom;
         return held[$urandom_range(held_n - 1)];
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OP_W-1:0]       req_operation;
   logic [KEY_W-1:0]      req_key;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [KEY_W-1:0]      rsp_value;
   logic                  rsp_last;
   logic [COUNT_W-1:0]    rsp_count;

   deque_scoreboard       sb;
   int unsigned           stall_cycles;

   deque_with_keyed_delete uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last),
      .rsp_count     (rsp_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      return $urandom_range(40, 6);
   endfunction

   function logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 45) return $urandom_range(7);
      if (r < 55) return (r < 50) ? '0 : '1;
      return $urandom;
   endfunction

   // mode 0 fills the list, mode 2 drains it, the others mix
   function logic [OP_W-1:0] pick_op(int mode);
      int r;
      int ins_pct;
      r = $urandom_range(99);
      ins_pct = (mode == 0) ? 85 : (mode == 2) ? 15 : 45;
      if (r < 3) return OP_W'($urandom_range(OP_LAST_RESERVED, OP_FIRST_RESERVED));
      if (r < 11) return OP_DUMP;
      if (r < 11 + ins_pct) return OP_INSERT;
      r = $urandom_range(3);
      if (r < 2) return OP_DEL_KEY;
      return (r == 2) ? OP_DEL_FIRST : OP_DEL_LAST;
   endfunction

   task automatic send_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input bit may_idle);
      int gap;
      gap = may_idle ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      do @(posedge clock); while (busy);
      sb.note_command(op, key);
   endtask

   // results cannot be held off, so every strobe is a transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_value, rsp_last, rsp_count);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("deque_with_keyed_delete_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int done;
      int mode;
      bit quiet;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;

      sb            = new();
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_INSERT;
      req_key       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, only entry deleted by key, duplicates, misses
      send_command(OP_DUMP, 32'h0, 1'b1);
      send_command(OP_DEL_KEY, 32'h0, 1'b1);
      send_command(OP_DEL_FIRST, 32'h0, 1'b1);
      send_command(OP_DEL_LAST, 32'h0, 1'b1);
      send_command(OP_INSERT, 32'h0, 1'b1);
      send_command(OP_DEL_KEY, 32'h0, 1'b1);
      send_command(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
      send_command(OP_INSERT, 32'h0, 1'b0);
      send_command(OP_INSERT, 32'hAAAA_AAAA, 1'b0);
      send_command(OP_INSERT, 32'h5555_5555, 1'b0);
      send_command(OP_INSERT, 32'h0, 1'b1);
      send_command(OP_DUMP, 32'h0, 1'b1);
      send_command(OP_DEL_KEY, 32'h0, 1'b1);
      send_command(OP_DEL_KEY, 32'h1234_5678, 1'b1);
      send_command(OP_DEL_KEY, 32'hFFFF_FFFF, 1'b1);
      send_command(OP_DUMP, 32'h0, 1'b0);
      send_command(OP_DEL_FIRST, 32'h0, 1'b1);
      send_command(OP_DEL_LAST, 32'h0, 1'b1);
      for (int c = OP_FIRST_RESERVED; c <= OP_LAST_RESERVED; c++)
         send_command(c[OP_W-1:0], $urandom, 1'b1);
      send_command(OP_DUMP, 32'h0, 1'b1);
      send_command(OP_DEL_LAST, 32'h0, 1'b1);
      send_command(OP_DUMP, 32'hFFFF_FFFF, 1'b1);

      done = 0;
      while (done < RANDOM_ITEMS) begin
         mode  = (done / SEGMENT) % 4;
         quiet = ((done / 15) % 3 == 0);
         op    = pick_op(mode);
         key   = pick_key();
         // most keyed deletes aim at a key that is actually held
         if (op == OP_DEL_KEY && $urandom_range(99) < 65) key = sb.random_held_key();
         send_command(op, key, !quiet);
         if (op < OP_FIRST_RESERVED) done++;
      end
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("deque_with_keyed_delete_tb: PASS");
      end else begin
         $display("deque_with_keyed_delete_tb: FAIL");
      end
      $finish;
   end

endmodule
